@@ rtl/ptc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types, sizes and helpers of the per-host traffic counter.
// ----------------------------------------------------------------------------
package ptc_pkg;

	localparam int HOSTS       = 16;
	localparam int UNMAPPED    = 64;
	localparam int COUNT_BITS  = 48;
	localparam int QUEUE_DEPTH = 2;

	localparam int HIDX_W  = (HOSTS > 1) ? $clog2(HOSTS) : 1;
	localparam int UIDX_W  = (UNMAPPED > 1) ? $clog2(UNMAPPED) : 1;
	localparam int FILL_W  = $clog2(UNMAPPED + 1);
	localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W   = COUNT_BITS + 1;

	localparam int S_TDATA_W = 136;
	localparam int M_TDATA_W = 144;

	localparam logic [15:0] IPV4_TYPE = 16'h0800;
	localparam logic [6:0]  HOSTS_LIM    = 7'(HOSTS);
	localparam logic [6:0]  UNMAPPED_LIM = 7'(UNMAPPED);

	typedef enum logic [1:0] {
		ACT_PACKET   = 2'd0,
		ACT_HOST_WR  = 2'd1,
		ACT_HOST_RD  = 2'd2,
		ACT_UNM_RD   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		STAT_COUNTED = 3'd0,
		STAT_IGNORED = 3'd1,
		STAT_WRITTEN = 3'd2,
		STAT_READ    = 3'd3,
		STAT_RANGE   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		K_PACKET,
		K_IGNORE,
		K_HOST_WR,
		K_HOST_RD,
		K_UNM_RD,
		K_BAD_SLOT
	} kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_MATCH,
		S_TX,
		S_RX,
		S_SCAN,
		S_URD,
		S_DONE
	} state_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] frame_len;
		logic [5:0]  slot;
		logic [31:0] entry_address;
		logic        entry_valid;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_out_t;

	typedef struct packed {
		status_t     status;
		logic        src_found;
		logic        dst_found;
		logic [47:0] tx_bytes;
		logic [47:0] rx_bytes;
		logic [31:0] read_address;
		logic        read_valid;
		logic [6:0]  unmapped_count;
		logic        unmapped_overflow;
	} result_t;

	function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] total,
		input logic [15:0] len);
		logic [SUM_W-1:0] sum;
		sum = {1'b0, total} + SUM_W'(len);
		return sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
	endfunction

	function automatic logic [47:0] to48(input logic [COUNT_BITS-1:0] total);
		logic [63:0] wide;
		wide = 64'(total);
		return wide[47:0];
	endfunction

endpackage
`default_nettype wire

@@ rtl/per_host_traffic_counter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// per_host_traffic_counter
// Per-host IPv4 byte counter with a deduplicated store of unmapped addresses.
// ----------------------------------------------------------------------------
// each item is popped in IDLE, executed in EXEC, taken through URD for store reads
//   or MATCH, TX and RX for packets, and loaded into the result register from DONE
// each unmapped address adds a store scan over the filled entries (one entry per
//   cycle through the single read port)
// one item executes at a time and DONE waits for the result register to be free;
//   a two-entry queue takes new words meanwhile; reset clears enables, totals, fill, flag
module per_host_traffic_counter (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// frame_type, src_ip, dst_ip, frame_len, slot, entry_address, entry_valid
	input  wire logic [ptc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	// action
	input  wire logic [1:0]                     s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// src_found, dst_found, tx_bytes, rx_bytes, read_address, read_valid,
	// unmapped_count, unmapped_overflow
	output logic [ptc_pkg::M_TDATA_W-1:0]       m_axis_tdata,
	// status
	output logic [2:0]                          m_axis_tuser
);

	logic                q_full;
	logic                q_push;
	logic                q_pop;
	ptc_pkg::item_t      q_item;
	ptc_pkg::queue_out_t q_head;
	ptc_pkg::result_t    res;

	ptc_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_item        (q_item)
	);

	ptc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head)
	);

	ptc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tuser = res.status;
	assign m_axis_tdata = {5'b0, res.unmapped_overflow, res.unmapped_count, res.read_valid,
		res.read_address, res.rx_bytes, res.tx_bytes, res.dst_found, res.src_found};

endmodule
`default_nettype wire

@@ rtl/ptc_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_front
// Input side: unpacks each word, classifies it and pushes it into the queue.
// ----------------------------------------------------------------------------
module ptc_front (
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire logic [ptc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	input  wire logic [1:0]                     s_axis_tuser,
	input  wire logic                           q_full,
	output logic                                q_push,
	output ptc_pkg::item_t                      q_item
);

	logic [15:0] frame_type;
	logic [6:0]  slot_ext;
	ptc_pkg::action_t action;

	assign action     = ptc_pkg::action_t'(s_axis_tuser);
	assign frame_type = s_axis_tdata[15:0];
	assign slot_ext   = {1'b0, s_axis_tdata[101:96]};

	assign s_axis_tready = !q_full;
	assign q_push        = s_axis_tvalid && !q_full;

	always_comb begin
		q_item.src_ip        = s_axis_tdata[47:16];
		q_item.dst_ip        = s_axis_tdata[79:48];
		q_item.frame_len     = s_axis_tdata[95:80];
		q_item.slot          = s_axis_tdata[101:96];
		q_item.entry_address = s_axis_tdata[133:102];
		q_item.entry_valid   = s_axis_tdata[134];
		case (action)
			ptc_pkg::ACT_PACKET: begin
				q_item.kind = (frame_type == ptc_pkg::IPV4_TYPE) ?
					ptc_pkg::K_PACKET : ptc_pkg::K_IGNORE;
			end
			ptc_pkg::ACT_HOST_WR: begin
				q_item.kind = (slot_ext >= ptc_pkg::HOSTS_LIM) ?
					ptc_pkg::K_BAD_SLOT : ptc_pkg::K_HOST_WR;
			end
			ptc_pkg::ACT_HOST_RD: begin
				q_item.kind = (slot_ext >= ptc_pkg::HOSTS_LIM) ?
					ptc_pkg::K_BAD_SLOT : ptc_pkg::K_HOST_RD;
			end
			ptc_pkg::ACT_UNM_RD: begin
				q_item.kind = (slot_ext >= ptc_pkg::UNMAPPED_LIM) ?
					ptc_pkg::K_BAD_SLOT : ptc_pkg::K_UNM_RD;
			end
			default: begin
				q_item.kind = ptc_pkg::K_BAD_SLOT;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/ptc_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_fifo
// Short queue of classified items between the front and the back end.
// ----------------------------------------------------------------------------
module ptc_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire ptc_pkg::item_t  push_item,
	output logic                 full,
	input  wire logic            pop,
	output ptc_pkg::queue_out_t  head
);

	ptc_pkg::item_t entry_q [ptc_pkg::QUEUE_DEPTH];
	logic [ptc_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [ptc_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [ptc_pkg::QCNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full       = (count_q == ptc_pkg::QCNT_W'(ptc_pkg::QUEUE_DEPTH));
	assign do_push    = push && !full;
	assign do_pop     = pop && (count_q != '0);
	assign head.valid = (count_q != '0);
	assign head.item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == ptc_pkg::QPTR_W'(ptc_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == ptc_pkg::QPTR_W'(ptc_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

@@ rtl/ptc_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_back
// Execution side: host table, saturating totals, unmapped-address store
// with a one-entry-per-cycle dedup scan, and the result register.
// ----------------------------------------------------------------------------
module ptc_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ptc_pkg::queue_out_t  head,
	output logic                      q_pop,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output ptc_pkg::result_t          out_res
);

	ptc_pkg::state_t state_q;
	ptc_pkg::state_t state_d;
	ptc_pkg::item_t  cur_q;

	// host table
	logic [31:0]                   host_addr_q [ptc_pkg::HOSTS];
	logic [ptc_pkg::HOSTS-1:0]     host_en_q;
	logic [ptc_pkg::COUNT_BITS-1:0] tx_tot_q [ptc_pkg::HOSTS];
	logic [ptc_pkg::COUNT_BITS-1:0] rx_tot_q [ptc_pkg::HOSTS];

	// unmapped store
	logic [31:0]                unm_mem [ptc_pkg::UNMAPPED];
	logic [31:0]                mem_rd_q;
	logic                       mem_rd_en;
	logic [ptc_pkg::UIDX_W-1:0] mem_rd_addr;
	logic                       mem_wr;
	logic [ptc_pkg::FILL_W-1:0] fill_q;
	logic                       fill_full;
	logic                       ovf_q;

	// lookup results
	logic                       hs_hit;
	logic                       hd_hit;
	logic [ptc_pkg::HIDX_W-1:0] hs_idx;
	logic [ptc_pkg::HIDX_W-1:0] hd_idx;
	logic                       hs_hit_q;
	logic                       hd_hit_q;
	logic [ptc_pkg::HIDX_W-1:0] hs_idx_q;
	logic [ptc_pkg::HIDX_W-1:0] hd_idx_q;
	logic [ptc_pkg::HIDX_W-1:0] slot_idx;

	// scan control
	logic [31:0]                scan_addr_q;
	logic                       scan_dst_q;
	logic [ptc_pkg::FILL_W-1:0] rd_idx_q;
	logic                       cmp_pend_q;
	logic                       scan_match;
	logic                       scan_end;
	logic                       scan_ins;
	logic                       scan_reload;
	logic                       scan_start;

	// working result
	ptc_pkg::status_t status_q;
	logic [47:0]      tx_q;
	logic [47:0]      rx_q;
	logic [31:0]      ra_q;
	logic             rv_q;
	logic             out_load;
	logic             out_valid_q;
	ptc_pkg::result_t out_q;

	assign slot_idx   = cur_q.slot[ptc_pkg::HIDX_W-1:0];
	assign fill_full  = (fill_q == ptc_pkg::FILL_W'(ptc_pkg::UNMAPPED));
	assign scan_match = cmp_pend_q && (mem_rd_q == scan_addr_q);
	assign mem_wr     = scan_ins && !fill_full;
	assign out_valid  = out_valid_q;
	assign out_res    = out_q;

	// parallel compare, lowest index wins
	always_comb begin
		hs_hit = 1'b0;
		hd_hit = 1'b0;
		hs_idx = '0;
		hd_idx = '0;
		for (int i = ptc_pkg::HOSTS - 1; i >= 0; i--) begin
			if (host_en_q[i] && (host_addr_q[i] == cur_q.src_ip)) begin
				hs_hit = 1'b1;
				hs_idx = ptc_pkg::HIDX_W'(i);
			end
			if (host_en_q[i] && (host_addr_q[i] == cur_q.dst_ip)) begin
				hd_hit = 1'b1;
				hd_idx = ptc_pkg::HIDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		q_pop       = 1'b0;
		mem_rd_en   = 1'b0;
		mem_rd_addr = '0;
		out_load    = 1'b0;
		scan_end    = 1'b0;
		scan_ins    = 1'b0;
		scan_reload = 1'b0;
		scan_start  = 1'b0;
		case (state_q)
			ptc_pkg::S_IDLE: begin
				if (head.valid) begin
					q_pop   = 1'b1;
					state_d = ptc_pkg::S_EXEC;
				end
			end
			ptc_pkg::S_EXEC: begin
				if (cur_q.kind == ptc_pkg::K_PACKET) begin
					state_d = ptc_pkg::S_MATCH;
				end else if (cur_q.kind == ptc_pkg::K_UNM_RD) begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = cur_q.slot[ptc_pkg::UIDX_W-1:0];
					state_d     = ptc_pkg::S_URD;
				end else begin
					state_d = ptc_pkg::S_DONE;
				end
			end
			ptc_pkg::S_MATCH: begin
				state_d = ptc_pkg::S_TX;
			end
			ptc_pkg::S_TX: begin
				state_d = ptc_pkg::S_RX;
			end
			ptc_pkg::S_RX: begin
				if (!hs_hit_q || !hd_hit_q) begin
					scan_start = 1'b1;
					state_d    = ptc_pkg::S_SCAN;
				end else begin
					state_d = ptc_pkg::S_DONE;
				end
			end
			ptc_pkg::S_SCAN: begin
				if (scan_match) begin
					scan_end = 1'b1;
				end else if (rd_idx_q < fill_q) begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = rd_idx_q[ptc_pkg::UIDX_W-1:0];
				end else begin
					scan_ins = 1'b1;
					scan_end = 1'b1;
				end
				if (scan_end) begin
					// source done, destination still to be tracked
					if (!scan_dst_q && !hd_hit_q) begin
						scan_reload = 1'b1;
					end else begin
						state_d = ptc_pkg::S_DONE;
					end
				end
			end
			ptc_pkg::S_URD: begin
				state_d = ptc_pkg::S_DONE;
			end
			ptc_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ptc_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ptc_pkg::S_IDLE;
			end
		endcase
	end

	// control state and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			host_en_q   <= '0;
			for (int i = 0; i < ptc_pkg::HOSTS; i++) begin
				tx_tot_q[i] <= '0;
				rx_tot_q[i] <= '0;
			end
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if ((state_q == ptc_pkg::S_EXEC) && (cur_q.kind == ptc_pkg::K_HOST_WR)) begin
				host_en_q[slot_idx] <= cur_q.entry_valid;
				tx_tot_q[slot_idx]  <= '0;
				rx_tot_q[slot_idx]  <= '0;
			end
			if ((state_q == ptc_pkg::S_TX) && hs_hit_q) begin
				tx_tot_q[hs_idx_q] <= ptc_pkg::sat_add(tx_tot_q[hs_idx_q], cur_q.frame_len);
			end
			if ((state_q == ptc_pkg::S_RX) && hd_hit_q) begin
				rx_tot_q[hd_idx_q] <= ptc_pkg::sat_add(rx_tot_q[hd_idx_q], cur_q.frame_len);
			end
			if (scan_ins) begin
				if (fill_full) begin
					ovf_q <= 1'b1;
				end else begin
					fill_q <= fill_q + 1'b1;
				end
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= head.item;
		end
		if ((state_q == ptc_pkg::S_EXEC) && (cur_q.kind == ptc_pkg::K_HOST_WR)) begin
			host_addr_q[slot_idx] <= cur_q.entry_address;
		end
		if (state_q == ptc_pkg::S_EXEC) begin
			hs_hit_q <= 1'b0;
			hd_hit_q <= 1'b0;
			tx_q     <= '0;
			rx_q     <= '0;
			ra_q     <= '0;
			rv_q     <= 1'b0;
			case (cur_q.kind)
				ptc_pkg::K_PACKET: begin
					status_q <= ptc_pkg::STAT_COUNTED;
				end
				ptc_pkg::K_IGNORE: begin
					status_q <= ptc_pkg::STAT_IGNORED;
				end
				ptc_pkg::K_HOST_WR: begin
					status_q <= ptc_pkg::STAT_WRITTEN;
				end
				ptc_pkg::K_HOST_RD: begin
					status_q <= ptc_pkg::STAT_READ;
					tx_q     <= ptc_pkg::to48(tx_tot_q[slot_idx]);
					rx_q     <= ptc_pkg::to48(rx_tot_q[slot_idx]);
					ra_q     <= host_addr_q[slot_idx];
					rv_q     <= host_en_q[slot_idx];
				end
				ptc_pkg::K_UNM_RD: begin
					status_q <= ptc_pkg::STAT_READ;
					rv_q     <= (7'(cur_q.slot) < 7'(fill_q));
				end
				default: begin
					status_q <= ptc_pkg::STAT_RANGE;
				end
			endcase
		end
		if (state_q == ptc_pkg::S_MATCH) begin
			hs_hit_q <= hs_hit;
			hd_hit_q <= hd_hit;
			hs_idx_q <= hs_idx;
			hd_idx_q <= hd_idx;
		end
		if (state_q == ptc_pkg::S_URD) begin
			ra_q <= rv_q ? mem_rd_q : 32'd0;
		end
		if (scan_start) begin
			scan_addr_q <= hs_hit_q ? cur_q.dst_ip : cur_q.src_ip;
			scan_dst_q  <= hs_hit_q;
			rd_idx_q    <= '0;
			cmp_pend_q  <= 1'b0;
		end else if (scan_reload) begin
			scan_addr_q <= cur_q.dst_ip;
			scan_dst_q  <= 1'b1;
			rd_idx_q    <= '0;
			cmp_pend_q  <= 1'b0;
		end else if ((state_q == ptc_pkg::S_SCAN) && mem_rd_en) begin
			rd_idx_q   <= rd_idx_q + 1'b1;
			cmp_pend_q <= 1'b1;
		end
		if (out_load) begin
			out_q.status            <= status_q;
			out_q.src_found         <= hs_hit_q;
			out_q.dst_found         <= hd_hit_q;
			out_q.tx_bytes          <= tx_q;
			out_q.rx_bytes          <= rx_q;
			out_q.read_address      <= ra_q;
			out_q.read_valid        <= rv_q;
			out_q.unmapped_count    <= 7'(fill_q);
			out_q.unmapped_overflow <= ovf_q;
		end
	end

	// unmapped address memory, registered read
	always_ff @(posedge clk) begin
		if (mem_wr) begin
			unm_mem[fill_q[ptc_pkg::UIDX_W-1:0]] <= scan_addr_q;
		end
		if (mem_rd_en) begin
			mem_rd_q <= unm_mem[mem_rd_addr];
		end
	end

	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |=> ovf_q)
		else $error("overflow flag cleared");

	a_ovf_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovf_q) |-> (fill_q == ptc_pkg::FILL_W'(ptc_pkg::UNMAPPED)))
		else $error("overflow raised with free store entries");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != $past(fill_q)) |-> (fill_q == $past(fill_q) + 1'b1))
		else $error("store fill moved by more than one");

endmodule
`default_nettype wire

@@ tb/sv/ptc_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// ptc_tb_pkg
// Word layout and scoreboard of the per-host traffic counter testbench. The
// scoreboard keeps its own host table, totals and unmapped store, works out
// the answer of every accepted word and checks returned words in order.
// ----------------------------------------------------------------------------
package ptc_tb_pkg;

	import ptc_pkg::*;

	typedef logic [COUNT_BITS-1:0] total_t;

	typedef struct packed {
		logic [15:0] frame_type;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] frame_len;
		logic [5:0]  slot;
		logic [31:0] entry_address;
		logic        entry_valid;
	} word_t;

	// lowest bit first: frame_type, src_ip, dst_ip, frame_len, slot, entry_address,
	// entry_valid, zero pad
	function automatic logic [S_TDATA_W-1:0] pack_word(input word_t w);
		return S_TDATA_W'({w.entry_valid, w.entry_address, w.slot, w.frame_len,
			w.dst_ip, w.src_ip, w.frame_type});
	endfunction

	function automatic word_t unpack_word(input logic [S_TDATA_W-1:0] d);
		word_t w;
		w.frame_type    = d[15:0];
		w.src_ip        = d[47:16];
		w.dst_ip        = d[79:48];
		w.frame_len     = d[95:80];
		w.slot          = d[101:96];
		w.entry_address = d[133:102];
		w.entry_valid   = d[134];
		return w;
	endfunction

	function automatic result_t unpack_result(input logic [M_TDATA_W-1:0] d,
		input logic [2:0] code);
		result_t r;
		r.status            = status_t'(code);
		r.src_found         = d[0];
		r.dst_found         = d[1];
		r.tx_bytes          = d[49:2];
		r.rx_bytes          = d[97:50];
		r.read_address      = d[129:98];
		r.read_valid        = d[130];
		r.unmapped_count    = d[137:131];
		r.unmapped_overflow = d[138];
		return r;
	endfunction

	class traffic_board;
		localparam total_t TOTAL_MAX = {COUNT_BITS{1'b1}};

		logic [31:0] host_addr [HOSTS];
		bit          host_on [HOSTS];
		total_t      tx_sum [HOSTS];
		total_t      rx_sum [HOSTS];
		logic [31:0] stray_addr [UNMAPPED];
		int unsigned stray_fill;
		bit          stray_lost;
		result_t     pending [$];
		int unsigned fails;
		int unsigned seen;

		function new();
			for (int i = 0; i < HOSTS; i++) begin
				host_addr[i] = '0;
				host_on[i]   = 1'b0;
				tx_sum[i]    = '0;
				rx_sum[i]    = '0;
			end
			stray_fill = 0;
			stray_lost = 1'b0;
			fails      = 0;
			seen       = 0;
		endfunction

		function int find_host(input logic [31:0] addr);
			for (int i = 0; i < HOSTS; i++)
				if (host_on[i] && host_addr[i] == addr)
					return i;
			return -1;
		endfunction

		function total_t add_len(input total_t t, input logic [15:0] len);
			if (t > TOTAL_MAX - total_t'(len))
				return TOTAL_MAX;
			return t + total_t'(len);
		endfunction

		// deduplicated; a new address with the store full only sets the lost flag
		function void remember_stray(input logic [31:0] addr);
			for (int i = 0; i < stray_fill; i++)
				if (stray_addr[i] == addr)
					return;
			if (stray_fill >= UNMAPPED) begin
				stray_lost = 1'b1;
				return;
			end
			stray_addr[stray_fill] = addr;
			stray_fill++;
		endfunction

		function void note_word(input action_t act, input word_t w);
			result_t r;
			int hs;
			int hd;
			r = '0;
			case (act)
				ACT_PACKET: begin
					if (w.frame_type != IPV4_TYPE) begin
						r.status = STAT_IGNORED;
					end else begin
						hs = find_host(w.src_ip);
						hd = find_host(w.dst_ip);
						if (hs >= 0) begin
							tx_sum[hs]  = add_len(tx_sum[hs], w.frame_len);
							r.src_found = 1'b1;
						end else begin
							remember_stray(w.src_ip);
						end
						if (hd >= 0) begin
							rx_sum[hd]  = add_len(rx_sum[hd], w.frame_len);
							r.dst_found = 1'b1;
						end else begin
							remember_stray(w.dst_ip);
						end
						r.status = STAT_COUNTED;
					end
				end
				ACT_HOST_WR: begin
					if (w.slot >= HOSTS) begin
						r.status = STAT_RANGE;
					end else begin
						host_addr[w.slot] = w.entry_address;
						host_on[w.slot]   = w.entry_valid;
						tx_sum[w.slot]    = '0;
						rx_sum[w.slot]    = '0;
						r.status          = STAT_WRITTEN;
					end
				end
				ACT_HOST_RD: begin
					if (w.slot >= HOSTS) begin
						r.status = STAT_RANGE;
					end else begin
						r.tx_bytes     = 48'(tx_sum[w.slot]);
						r.rx_bytes     = 48'(rx_sum[w.slot]);
						r.read_address = host_addr[w.slot];
						r.read_valid   = host_on[w.slot];
						r.status       = STAT_READ;
					end
				end
				default: begin
					if (w.slot >= UNMAPPED) begin
						r.status = STAT_RANGE;
					end else begin
						if (w.slot < stray_fill) begin
							r.read_address = stray_addr[w.slot];
							r.read_valid   = 1'b1;
						end
						r.status = STAT_READ;
					end
				end
			endcase
			r.unmapped_count    = 7'(stray_fill);
			r.unmapped_overflow = stray_lost;
			pending.push_back(r);
		endfunction

		task report(input string msg);
			$display("mismatch: %s", msg);
			fails++;
		endtask

		task compare(input string name, input logic [63:0] got, input logic [63:0] want);
			if (got !== want)
				report($sformatf("word %0d %s got %0h expected %0h", seen, name, got, want));
		endtask

		task check_word(input result_t got);
			result_t want;
			if (pending.size() == 0) begin
				report($sformatf("word %0d arrived with nothing outstanding", seen));
			end else begin
				want = pending.pop_front();
				compare("status", 64'(got.status), 64'(want.status));
				compare("src_found", 64'(got.src_found), 64'(want.src_found));
				compare("dst_found", 64'(got.dst_found), 64'(want.dst_found));
				compare("tx_bytes", 64'(got.tx_bytes), 64'(want.tx_bytes));
				compare("rx_bytes", 64'(got.rx_bytes), 64'(want.rx_bytes));
				compare("read_address", 64'(got.read_address), 64'(want.read_address));
				compare("read_valid", 64'(got.read_valid), 64'(want.read_valid));
				compare("unmapped_count", 64'(got.unmapped_count),
					64'(want.unmapped_count));
				compare("unmapped_overflow", 64'(got.unmapped_overflow),
					64'(want.unmapped_overflow));
			end
			seen++;
		endtask
	endclass

endpackage

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the per-host traffic counter. A directed run loads hosts,
// counts edge-case packets and reads back totals and the unmapped store, then
// random traffic drawn from small address pools fills the store past its limit
// while both stream sides stall at random in the first two phases. Every returned word is checked.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import ptc_pkg::*;
	import ptc_tb_pkg::*;

	localparam int RANDOM_WORDS = 1230;
	localparam int HOST_POOL    = 12;
	localparam int STRAY_POOL   = 90;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic [1:0]           s_axis_tuser = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic [2:0]           m_axis_tuser;

	traffic_board board = new();
	int unsigned  send_idle = 0;
	int unsigned  recv_idle = 0;
	bit           host_loaded [HOSTS];
	logic [31:0]  host_pool [HOST_POOL];
	logic [31:0]  stray_pool [STRAY_POOL];

	per_host_traffic_counter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("TB_ERROR");
		$finish;
	end

	always @(negedge clk) begin
		m_axis_tready = ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_word(unpack_result(m_axis_tdata, m_axis_tuser));
		if (arst_n && s_axis_tvalid && s_axis_tready)
			board.note_word(action_t'(s_axis_tuser), unpack_word(s_axis_tdata));
	end

	function automatic word_t any_word();
		word_t w;
		w.frame_type    = 16'($urandom);
		w.src_ip        = $urandom;
		w.dst_ip        = $urandom;
		w.frame_len     = 16'($urandom);
		w.slot          = 6'($urandom);
		w.entry_address = $urandom;
		w.entry_valid   = 1'($urandom);
		return w;
	endfunction

	function automatic logic [31:0] pick_addr();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 50)
			return host_pool[$urandom_range(HOST_POOL - 1)];
		if (r < 90)
			return stray_pool[$urandom_range(STRAY_POOL - 1)];
		return $urandom;
	endfunction

	task automatic send_word(input action_t act, input word_t w);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tdata  = pack_word(w);
		s_axis_tuser  = act;
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_packet(input logic [15:0] etype, input logic [31:0] src,
		input logic [31:0] dst, input logic [15:0] len);
		word_t w;
		w            = any_word();
		w.frame_type = etype;
		w.src_ip     = src;
		w.dst_ip     = dst;
		w.frame_len  = len;
		send_word(ACT_PACKET, w);
	endtask

	task automatic send_slot(input action_t act, input logic [5:0] slot,
		input logic [31:0] addr, input logic valid);
		word_t w;
		w               = any_word();
		w.slot          = slot;
		w.entry_address = addr;
		w.entry_valid   = valid;
		if (act == ACT_HOST_WR && slot < HOSTS)
			host_loaded[slot] = 1'b1;
		send_word(act, w);
	endtask

	task automatic random_word();
		int unsigned r;
		int          s;
		logic [31:0] src;
		r = $urandom_range(99);
		if (r < 65) begin
			src = pick_addr();
			if ($urandom_range(9) == 0)
				send_packet(16'($urandom), src, pick_addr(), 16'($urandom));
			else if ($urandom_range(9) == 0)
				send_packet(IPV4_TYPE, src, src, 16'($urandom));
			else
				send_packet(IPV4_TYPE, src, pick_addr(), 16'($urandom));
		end else if (r < 75) begin
			if ($urandom_range(9) == 0 && HOSTS < 64)
				s = $urandom_range(63, HOSTS);
			else
				s = $urandom_range(HOSTS - 1);
			send_slot(ACT_HOST_WR, 6'(s),
				($urandom_range(99) < 85) ? host_pool[$urandom_range(HOST_POOL - 1)]
					: $urandom,
				$urandom_range(99) < 85);
		end else if (r < 87) begin
			// host reads mostly go to slots loaded at least once, else to an out-of-range slot
			s = -1;
			if ($urandom_range(9) != 0 || HOSTS >= 64) begin
				r = $urandom_range(HOSTS - 1);
				for (int i = 0; i < HOSTS && s < 0; i++)
					if (host_loaded[(r + i) % HOSTS])
						s = (r + i) % HOSTS;
			end
			if (s < 0)
				s = (HOSTS < 64) ? $urandom_range(63, HOSTS) : 0;
			send_slot(ACT_HOST_RD, 6'(s), $urandom, 1'($urandom));
		end else begin
			s = ($urandom_range(1) == 0) ? $urandom_range(63) : $urandom_range(15);
			send_slot(ACT_UNM_RD, 6'(s), $urandom, 1'($urandom));
		end
	endtask

	task automatic directed_words();
		logic [31:0] a;
		logic [31:0] b;
		a = host_pool[0];
		b = host_pool[1];
		send_slot(ACT_UNM_RD, 6'd0, $urandom, 1'b1);
		send_slot(ACT_HOST_WR, 6'd0, a, 1'b1);
		send_slot(ACT_HOST_WR, 6'(HOSTS - 1), 32'hFFFF_FFFF, 1'b1);
		send_slot(ACT_HOST_WR, 6'd1, 32'h0000_0000, 1'b1);
		// same address on a higher slot: the lower slot must win
		send_slot(ACT_HOST_WR, 6'd2, a, 1'b1);
		send_slot(ACT_HOST_WR, 6'd3, b, 1'b0);
		send_slot(ACT_HOST_WR, 6'(HOSTS), $urandom, 1'b1);
		send_slot(ACT_HOST_WR, 6'd63, $urandom, 1'b1);
		send_slot(ACT_HOST_RD, 6'd63, $urandom, 1'b0);
		send_packet(IPV4_TYPE, a, 32'hFFFF_FFFF, 16'hFFFF);
		send_packet(IPV4_TYPE, a, a, 16'h0000);
		send_packet(IPV4_TYPE, 32'h0000_0000, a, 16'h0001);
		// one stray on both sides is stored once; two strays, source first
		send_packet(IPV4_TYPE, stray_pool[0], stray_pool[0], 16'd64);
		send_packet(IPV4_TYPE, stray_pool[1], stray_pool[2], 16'd1500);
		// disabled host counts as a miss
		send_packet(IPV4_TYPE, b, 32'h0000_0000, 16'd60);
		send_packet(16'h86DD, a, a, 16'd100);
		send_packet(16'hFFFF, a, b, 16'hFFFF);
		send_packet(16'h0000, a, b, 16'd1);
		send_packet(16'h0801, a, a, 16'd1);
		send_slot(ACT_HOST_RD, 6'd0, $urandom, 1'b1);
		send_slot(ACT_HOST_RD, 6'd2, $urandom, 1'b1);
		send_slot(ACT_HOST_RD, 6'(HOSTS - 1), $urandom, 1'b1);
		send_slot(ACT_HOST_RD, 6'd3, $urandom, 1'b1);
		// reloading a host clears its totals
		send_slot(ACT_HOST_WR, 6'd0, a, 1'b1);
		send_slot(ACT_HOST_RD, 6'd0, $urandom, 1'b0);
		send_slot(ACT_UNM_RD, 6'd2, $urandom, 1'b0);
		send_slot(ACT_UNM_RD, 6'd63, $urandom, 1'b0);
	endtask

	initial begin
		for (int i = 0; i < HOSTS; i++)
			host_loaded[i] = 1'b0;
		for (int i = 0; i < HOST_POOL; i++)
			host_pool[i] = $urandom;
		for (int i = 0; i < STRAY_POOL; i++)
			stray_pool[i] = $urandom;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle = 35;
		recv_idle = 73;
		directed_words();
		for (int phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 35 : (phase == 1) ? 73 : 0;
			recv_idle = (phase == 0) ? 73 : (phase == 1) ? 35 : 0;
			for (int n = 0; n < RANDOM_WORDS / 3; n++)
				random_word();
		end
		@(negedge clk);
		s_axis_tvalid = 1'b0;

		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (board.pending.size() != 0)
			board.report($sformatf("%0d words never returned", board.pending.size()));
		if (board.fails == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
